[rtl/sandpile_grid_relaxer_defines.svh]
// ----------------------------------------------------------------------------
// Sandpile grid relaxer assertion macros
// Shorthand for clocked concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SANDPILE_GRID_RELAXER_DEFINES_SVH
`define SANDPILE_GRID_RELAXER_DEFINES_SVH

// Check held at every rising clock edge outside reset
`define SGR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on the cycle after a condition, outside reset
`define SGR_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

[rtl/sgr_pkg.sv]
// ----------------------------------------------------------------------------
// Sandpile grid relaxer package
// Grid geometry, item structs, operation and register codes.
// ----------------------------------------------------------------------------
package sgr_pkg;

  // Grid geometry
  localparam int GRID_HEIGHT = 64;
  localparam int GRID_WIDTH  = 64;
  localparam int CELL_BITS   = 16;

  localparam int ROW_W  = $clog2(GRID_HEIGHT);
  localparam int COL_W  = $clog2(GRID_WIDTH);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = GRID_HEIGHT * GRID_WIDTH;
  localparam int CNT_W  = 7;
  localparam int ACC_W  = CELL_BITS + 1;

  localparam logic [CELL_BITS-1:0] CELL_TOP  = '1;
  localparam logic [7:0]           COLOR_ON  = 8'd255;
  localparam logic [31:0]          SWEEP_TOP = '1;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RELAX = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLS = 1'd1;

  localparam logic [CNT_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [CNT_W-1:0] COLS_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] sweeps;
    logic        status;
  } out_item_t;

endpackage

[rtl/sandpile_grid_relaxer.sv]
// ----------------------------------------------------------------------------
// Sandpile grid relaxer
// 64x64 abelian sandpile held in block memory, relaxed by synchronous sweeps.
// ----------------------------------------------------------------------------
// Usage:
//   Input items are taken on start while busy is low. Each item gives one
//   result on out_item, marked by out_strobe for a single cycle; the receiver
//   cannot stall it, so it must take every strobe.
//   Cell write and read: result in the cycle after accept, busy stays low,
//   one item per cycle.
//   Relax: busy for the whole run. Each sweep walks every cell in use through
//   one shared adder, reading the center and four neighbors in turn from the
//   single read port of the grid memory, then copies the new grid back at
//   one cell per cycle; the result strobes once the copy after a sweep that
//   changed nothing is done. A relax on an empty grid answers next cycle.
//   Reset: the grid memory is cleared by a pass over all 4096 cells, one cell
//   per cycle; busy is high meanwhile. Configuration writes via cfg_* are
//   always ready and are meant to be made while the block is idle.
// ----------------------------------------------------------------------------
module sandpile_grid_relaxer import sgr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_strobe,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_COPY  = 4'b1000
  } state_t;

  // Sweep step codes: reads issued at steps 0..4, last data at step 5
  localparam logic [2:0] ST_CENTER = 3'd0;
  localparam logic [2:0] ST_LEFT   = 3'd1;
  localparam logic [2:0] ST_RIGHT  = 3'd2;
  localparam logic [2:0] ST_UP     = 3'd3;
  localparam logic [2:0] ST_DOWN   = 3'd4;
  localparam logic [2:0] ST_LAST   = 3'd5;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     rows_r, cols_r;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [2:0]           step_r, step_nxt;
  logic [ADDR_W-1:0]    clr_r, clr_nxt;
  logic                 run_r, run_nxt;
  logic                 wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0]    wr_addr_r, wr_addr_nxt;
  logic                 changed_r, changed_nxt;
  logic [31:0]          sweeps_r, sweeps_nxt;
  logic                 tap_ok_r, tap_ok;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [CELL_BITS-1:0] center_r, center_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  logic                 out_rd_r, out_rd_nxt;
  logic                 out_status_r, out_status_nxt;

  // Grid memories
  logic [CELL_BITS-1:0] cur_mem [DEPTH];
  logic [CELL_BITS-1:0] nxt_mem [DEPTH];
  logic [CELL_BITS-1:0] cur_rdata_r, nxt_rdata_r;
  logic                 cur_we, nxt_we;
  logic [ADDR_W-1:0]    cur_waddr, cur_raddr, nxt_addr, tap_addr, pos_addr;
  logic [CELL_BITS-1:0] cur_wdata;

  logic [CNT_W-1:0]     nr, nc;
  logic                 in_grid, accept, last_pos, last_col;
  logic [CELL_BITS-1:0] term, sum_sat, cv;
  logic [ACC_W-1:0]     sum;
  logic [31:0]          sweeps_inc;

  // Effective grid size
  assign nr = (rows_r > CNT_W'(GRID_HEIGHT)) ? CNT_W'(GRID_HEIGHT) : rows_r;
  assign nc = (cols_r > CNT_W'(GRID_WIDTH))  ? CNT_W'(GRID_WIDTH)  : cols_r;

  assign in_grid = ({1'b0, in_item.row} < nr) && ({1'b0, in_item.col} < nc);
  assign accept  = start && !busy;
  assign busy    = (state_r != S_IDLE);

  // Cell walk position
  assign pos_addr = {row_r, col_r};
  assign last_col = ({1'b0, col_r} + CNT_W'(1)) == nc;
  assign last_pos = last_col && (({1'b0, row_r} + CNT_W'(1)) == nr);

  // Neighbor tap address and whether it lies in the grid in use
  always_comb begin
    tap_addr = pos_addr;
    tap_ok   = 1'b1;
    case (step_r)
      ST_LEFT: begin
        tap_addr = {row_r, col_r - COL_W'(1)};
        tap_ok   = (col_r != '0);
      end
      ST_RIGHT: begin
        tap_addr = {row_r, col_r + COL_W'(1)};
        tap_ok   = ({1'b0, col_r} + CNT_W'(1)) < nc;
      end
      ST_UP: begin
        tap_addr = {row_r - ROW_W'(1), col_r};
        tap_ok   = (row_r != '0);
      end
      ST_DOWN: begin
        tap_addr = {row_r + ROW_W'(1), col_r};
        tap_ok   = ({1'b0, row_r} + CNT_W'(1)) < nr;
      end
      default: begin
        tap_addr = pos_addr;
        tap_ok   = 1'b1;
      end
    endcase
  end

  // Shared adder: accumulate one quarter per cycle
  assign term    = tap_ok_r ? (cur_rdata_r >> 2) : '0;
  assign sum     = acc_r + {1'b0, term};
  assign sum_sat = (sum > {1'b0, CELL_TOP}) ? CELL_TOP : sum[CELL_BITS-1:0];

  assign sweeps_inc = (sweeps_r != SWEEP_TOP) ? sweeps_r + 32'd1 : sweeps_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    step_nxt       = step_r;
    clr_nxt        = clr_r;
    run_nxt        = run_r;
    wr_pend_nxt    = 1'b0;
    wr_addr_nxt    = pos_addr;
    changed_nxt    = changed_r;
    sweeps_nxt     = sweeps_r;
    acc_nxt        = acc_r;
    center_nxt     = center_r;
    out_strobe_nxt = 1'b0;
    out_rd_nxt     = 1'b0;
    out_status_nxt = 1'b0;
    cur_we         = 1'b0;
    cur_waddr      = {in_item.row, in_item.col};
    cur_wdata      = in_item.value;
    cur_raddr      = {in_item.row, in_item.col};
    nxt_we         = 1'b0;
    nxt_addr       = pos_addr;
    case (state_r)
      S_CLEAR: begin
        cur_we    = 1'b1;
        cur_waddr = clr_r;
        cur_wdata = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          out_strobe_nxt = 1'b1;
          case (in_item.operation)
            OP_WRITE: begin
              cur_we         = in_grid;
              out_status_nxt = !in_grid;
            end
            OP_READ: begin
              out_rd_nxt     = in_grid;
              out_status_nxt = !in_grid;
            end
            OP_RELAX: begin
              if (nr == '0 || nc == '0) begin
                sweeps_nxt = 32'd1;
              end else begin
                sweeps_nxt     = '0;
                out_strobe_nxt = 1'b0;
                state_nxt      = S_SWEEP;
                row_nxt        = '0;
                col_nxt        = '0;
                step_nxt       = ST_CENTER;
                changed_nxt    = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        cur_raddr = tap_addr;
        step_nxt  = step_r + 3'd1;
        if (step_r == ST_LEFT) begin
          center_nxt = cur_rdata_r;
          acc_nxt    = ACC_W'(cur_rdata_r[1:0]);
        end else if (step_r != ST_CENTER) begin
          acc_nxt = sum;
        end
        if (step_r == ST_LAST) begin
          nxt_we   = 1'b1;
          step_nxt = ST_CENTER;
          if (sum_sat != center_r) changed_nxt = 1'b1;
          if (last_pos) begin
            state_nxt = S_COPY;
            row_nxt   = '0;
            col_nxt   = '0;
            run_nxt   = 1'b1;
          end else if (last_col) begin
            col_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end
      end
      S_COPY: begin
        // read new grid one cell per cycle, write each cell back in the following cycle
        cur_we    = wr_pend_r;
        cur_waddr = wr_addr_r;
        cur_wdata = nxt_rdata_r;
        if (run_r) begin
          wr_pend_nxt = 1'b1;
          if (last_pos) begin
            run_nxt = 1'b0;
          end else if (last_col) begin
            col_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end else if (!wr_pend_r) begin
          sweeps_nxt = sweeps_inc;
          if (changed_r) begin
            state_nxt   = S_SWEEP;
            row_nxt     = '0;
            col_nxt     = '0;
            step_nxt    = ST_CENTER;
            changed_nxt = 1'b0;
          end else begin
            state_nxt      = S_IDLE;
            out_strobe_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Current grid memory
  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
    cur_rdata_r <= cur_mem[cur_raddr];
  end

  // Next grid memory
  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_addr] <= sum_sat;
    nxt_rdata_r <= nxt_mem[nxt_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      run_r        <= 1'b0;
      wr_pend_r    <= 1'b0;
      changed_r    <= 1'b0;
      sweeps_r     <= '0;
      step_r       <= ST_CENTER;
      out_strobe_r <= 1'b0;
      rows_r       <= ROWS_RESET;
      cols_r       <= COLS_RESET;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      run_r        <= run_nxt;
      wr_pend_r    <= wr_pend_nxt;
      changed_r    <= changed_nxt;
      sweeps_r     <= sweeps_nxt;
      step_r       <= step_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS: rows_r <= cfg_data;
          REG_COLS: cols_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    wr_addr_r    <= wr_addr_nxt;
    tap_ok_r     <= tap_ok;
    acc_r        <= acc_nxt;
    center_r     <= center_nxt;
    out_rd_r     <= out_rd_nxt;
    out_status_r <= out_status_nxt;
  end

  assign cfg_ready = 1'b1;

  // Result item
  assign cv         = out_rd_r ? cur_rdata_r : '0;
  assign out_strobe = out_strobe_r;

  always_comb begin
    out_item            = '0;
    out_item.cell_value = cv;
    out_item.green      = (cv == CELL_BITS'(1)) ? COLOR_ON : '0;
    out_item.blue       = (cv == CELL_BITS'(2)) ? COLOR_ON : '0;
    out_item.red        = (cv == CELL_BITS'(3)) ? COLOR_ON : '0;
    out_item.sweeps     = sweeps_r;
    out_item.status     = out_status_r;
  end

endmodule

[rtl/sgr_checker.sv]
// ----------------------------------------------------------------------------
// Sandpile grid relaxer port checker
// Watches the top level ports for result timing and content rules.
// ----------------------------------------------------------------------------
`include "sandpile_grid_relaxer_defines.svh"

module sgr_checker import sgr_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input in_item_t             in_item,
  input logic                 out_strobe,
  input out_item_t            out_item
);

  // Cell writes and reads answer on the next cycle
  `SGR_ASSERT_NEXT(a_rw_next, start && !busy && (in_item.operation == OP_WRITE || in_item.operation == OP_READ), out_strobe, "cell access item gave no result next cycle")

  // A write item returns no cell data
  `SGR_ASSERT_NEXT(a_wr_blank, start && !busy && in_item.operation == OP_WRITE, out_item.cell_value == 16'd0 && out_item.red == 8'd0 && out_item.green == 8'd0 && out_item.blue == 8'd0, "write item returned cell data")

  // A result follows an accepted item or the end of a busy run
  `SGR_ASSERT(a_no_stray, out_strobe |-> ($past(start && !busy) || $past(busy)), "result with no item in flight")

  // At most one color channel lit
  `SGR_ASSERT(a_one_color, out_strobe |-> $onehot0({out_item.red != 8'd0, out_item.green != 8'd0, out_item.blue != 8'd0}), "more than one color channel lit")

endmodule

bind sandpile_grid_relaxer sgr_checker u_sgr_checker (.*);

[tb/sv/sandpile_check_pkg.sv]
// ----------------------------------------------------------------------------
// Sandpile relaxer scoreboard
// Keeps its own copy of the grain grid and the grid size registers, works out
// the reply that each accepted command should produce, and checks the block's
// replies in order, field by field.
// ----------------------------------------------------------------------------
package sandpile_check_pkg;
  import sgr_pkg::*;

  // Operation code the block leaves unused
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class sandpile_checker;
    logic [CELL_BITS-1:0] grains [DEPTH];
    logic [CELL_BITS-1:0] next_grains [DEPTH];
    logic [CNT_W-1:0]     rows_reg;
    logic [CNT_W-1:0]     cols_reg;
    logic [31:0]          sweep_total;
    out_item_t            pending_replies [$];
    int                   errors;

    function new();
      foreach (grains[i]) begin
        grains[i] = '0;
        next_grains[i] = '0;
      end
      rows_reg = ROWS_RESET;
      cols_reg = COLS_RESET;
      sweep_total = '0;
      errors = 0;
    endfunction

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
      if (idx == REG_ROWS) rows_reg = data;
      else if (idx == REG_COLS) cols_reg = data;
    endfunction

    // Sizes above the grid saturate to the grid
    function int rows_active();
      return (rows_reg > GRID_HEIGHT) ? GRID_HEIGHT : int'(rows_reg);
    endfunction

    function int cols_active();
      return (cols_reg > GRID_WIDTH) ? GRID_WIDTH : int'(cols_reg);
    endfunction

    // Grains a neighbor hands over; anything off the grid in use is a sink
    function int unsigned spill_from(int r, int c, int nr, int nc);
      if (r < 0 || c < 0 || r >= nr || c >= nc) return 0;
      return grains[r * GRID_WIDTH + c] / 4;
    endfunction

    // One synchronous sweep over the cells in use; returns whether any changed
    function bit relax_sweep(int nr, int nc);
      bit          changed;
      int          idx;
      int unsigned sum;
      changed = 1'b0;
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          idx = r * GRID_WIDTH + c;
          sum = grains[idx] % 4;
          sum += spill_from(r, c - 1, nr, nc) + spill_from(r, c + 1, nr, nc);
          sum += spill_from(r - 1, c, nr, nc) + spill_from(r + 1, c, nr, nc);
          if (sum > CELL_TOP) sum = CELL_TOP;
          next_grains[idx] = CELL_BITS'(sum);
          if (next_grains[idx] != grains[idx]) changed = 1'b1;
        end
      end
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          grains[r * GRID_WIDTH + c] = next_grains[r * GRID_WIDTH + c];
        end
      end
      return changed;
    endfunction

    // Accepted command: update the grid copy and queue the reply it causes
    function void take_command(in_item_t it);
      out_item_t            exp;
      int                   nr;
      int                   nc;
      int                   idx;
      bit                   in_bounds;
      bit                   changed;
      logic [CELL_BITS-1:0] cnt;
      exp = '0;
      nr = rows_active();
      nc = cols_active();
      in_bounds = (int'(it.row) < nr) && (int'(it.col) < nc);
      idx = it.row * GRID_WIDTH + it.col;
      case (it.operation)
        OP_WRITE: begin
          if (in_bounds) grains[idx] = (it.value > CELL_TOP) ? CELL_TOP : CELL_BITS'(it.value);
          else exp.status = 1'b1;
        end
        OP_RELAX: begin
          sweep_total = '0;
          do begin
            changed = relax_sweep(nr, nc);
            if (sweep_total != SWEEP_TOP) sweep_total++;
          end while (changed);
        end
        OP_READ: begin
          if (in_bounds) begin
            cnt = grains[idx];
            exp.cell_value = (cnt > 16'hFFFF) ? 16'hFFFF : 16'(cnt);
            if (cnt == 1) exp.green = COLOR_ON;
            else if (cnt == 2) exp.blue = COLOR_ON;
            else if (cnt == 3) exp.red = COLOR_ON;
          end else begin
            exp.status = 1'b1;
          end
        end
        default: ;
      endcase
      exp.sweeps = sweep_total;
      pending_replies.push_back(exp);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got,
                                longint unsigned stamp);
      if (want != got) begin
        errors++;
        $display("%0d ns: %s mismatch, expected %0d, actual %0d", stamp, name, want, got);
      end
    endfunction

    // Reply from the block, matched against the oldest expectation
    function void check_reply(out_item_t got, longint unsigned stamp);
      out_item_t exp;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0d ns: reply with none expected, expected nothing, actual %p", stamp, got);
        return;
      end
      exp = pending_replies.pop_front();
      compare_field("cell_value", exp.cell_value, got.cell_value, stamp);
      compare_field("red", exp.red, got.red, stamp);
      compare_field("green", exp.green, got.green, stamp);
      compare_field("blue", exp.blue, got.blue, stamp);
      compare_field("sweeps", exp.sweeps, got.sweeps, stamp);
      compare_field("status", exp.status, got.status, stamp);
    endfunction
  endclass

endpackage

[tb/sv/sandpile_grid_relaxer_test.sv]
// ----------------------------------------------------------------------------
// Sandpile grid relaxer testbench
// Directed corner, color, bounds and grid size commands, then phases of random
// writes, reads and relaxes over many grid sizes with random start gaps. Every
// reply is checked against the scoreboard's own grid copy.
// ----------------------------------------------------------------------------
module sandpile_grid_relaxer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sgr_pkg::*;
  import sandpile_check_pkg::*;

  localparam int     NUM_PHASES    = 14;
  localparam int     PHASE_ITEMS   = 100;
  localparam int     SETTLE_CYCLES = 8;
  localparam longint CYCLE_LIMIT   = 6_000_000;

  // How wide written values may go, picked from the number of cells in use
  localparam int SPAN_TINY  = 0;
  localparam int SPAN_MID   = 1;
  localparam int SPAN_LARGE = 2;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_item = '0;
  logic                 out_strobe;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data = '0;
  longint               cycle_count = 0;
  sandpile_checker      tracker = new();

  sandpile_grid_relaxer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_strobe(out_strobe),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Reply monitor; the receiver never stalls
  always @(posedge clk) begin
    if (rst_n && out_strobe) tracker.check_reply(out_item, $time);
  end

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(bit burst);
    int roll;
    roll = $urandom_range(99);
    if (burst || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, int r, int c, int v);
    in_item_t it;
    it.operation = op;
    it.row = 6'(r);
    it.col = 6'(c);
    it.value = 16'(v);
    return it;
  endfunction

  function automatic in_item_t random_command(int nr, int nc, int span);
    in_item_t it;
    int       roll;
    it.value = 16'($urandom_range(65535));
    roll = $urandom_range(99);
    if (roll < 46) it.operation = OP_WRITE;
    else if (roll < 86) it.operation = OP_READ;
    else if (roll < 93 && span != SPAN_LARGE) it.operation = OP_RELAX;
    else if (roll < 93) it.operation = OP_WRITE;
    else it.operation = OP_UNUSED;
    // mostly inside the grid in use, the rest anywhere
    if (nr > 0 && nc > 0 && $urandom_range(99) < 85) begin
      it.row = 6'($urandom_range(nr - 1));
      it.col = 6'($urandom_range(nc - 1));
    end else begin
      it.row = 6'($urandom_range(63));
      it.col = 6'($urandom_range(63));
    end
    // keep relax runs short: big piles only on tiny grids
    if (it.operation == OP_WRITE) begin
      case (span)
        SPAN_TINY: begin
          if ($urandom_range(1) == 1) it.value = 16'($urandom_range(65535));
          else it.value = 16'($urandom_range(7));
        end
        SPAN_MID: begin
          if ($urandom_range(99) < 4) it.value = 16'($urandom_range(255));
          else it.value = 16'($urandom_range(15));
        end
        default: it.value = 16'($urandom_range(3));
      endcase
    end
    return it;
  endfunction

  // Present one command and hold it until taken
  task automatic send_command(input in_item_t it, input int gap);
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    tracker.take_command(it);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write both size registers, valid held across the pair
  task automatic resize_grid(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols);
    while (busy) @(posedge clk);
    cfg_index <= REG_ROWS;
    cfg_data <= rows;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(REG_ROWS, rows);
    cfg_index <= REG_COLS;
    cfg_data <= cols;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(REG_COLS, cols);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every reply, then a short settle
  task automatic drain_results();
    start <= 1'b0;
    while (tracker.pending_replies.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int rows_plan [NUM_PHASES] = '{1, 1, 64, 2, 0, 5, 64, 100, -1, -1, -1, -1, -1, 127};
    int cols_plan [NUM_PHASES] = '{1, 64, 1, 2, 3, 0, 64, 2, -1, -1, -1, -1, -1, 127};
    int rows;
    int cols;
    int nr;
    int nc;
    int span;
    bit burst;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset size: corners, all four colors, unused code, one quiet relax
    send_command(make_item(OP_WRITE, 0, 0, 3), pick_gap(1'b0));
    send_command(make_item(OP_WRITE, 63, 63, 2), pick_gap(1'b0));
    send_command(make_item(OP_WRITE, 0, 63, 1), pick_gap(1'b0));
    send_command(make_item(OP_WRITE, 63, 0, 0), pick_gap(1'b0));
    send_command(make_item(OP_READ, 0, 0, 0), pick_gap(1'b0));
    send_command(make_item(OP_READ, 63, 63, 16'hFFFF), pick_gap(1'b0));
    send_command(make_item(OP_READ, 0, 63, 0), pick_gap(1'b0));
    send_command(make_item(OP_READ, 63, 0, 0), pick_gap(1'b0));
    send_command(make_item(OP_UNUSED, 63, 63, 16'hFFFF), pick_gap(1'b0));
    send_command(make_item(OP_RELAX, 0, 0, 0), pick_gap(1'b0));
    drain_results();

    // 2x2 grid: full-scale pile, out of bounds write and read, relax
    resize_grid(7'd2, 7'd2);
    send_command(make_item(OP_WRITE, 1, 1, 16'hFFFF), pick_gap(1'b0));
    send_command(make_item(OP_READ, 1, 1, 0), pick_gap(1'b0));
    send_command(make_item(OP_WRITE, 5, 5, 7), pick_gap(1'b0));
    send_command(make_item(OP_READ, 63, 63, 0), pick_gap(1'b0));
    send_command(make_item(OP_RELAX, 0, 0, 0), pick_gap(1'b0));
    send_command(make_item(OP_READ, 1, 1, 0), pick_gap(1'b0));
    send_command(make_item(OP_READ, 0, 0, 0), pick_gap(1'b0));
    drain_results();

    // No rows in use: empty relax, everything out of bounds
    resize_grid(7'd0, 7'd2);
    send_command(make_item(OP_RELAX, 0, 0, 0), pick_gap(1'b0));
    send_command(make_item(OP_WRITE, 0, 0, 1), pick_gap(1'b0));
    send_command(make_item(OP_READ, 0, 0, 0), pick_gap(1'b0));
    drain_results();

    // Oversize saturates to full grid; cells left outside kept their counts
    resize_grid(7'd127, 7'd127);
    send_command(make_item(OP_READ, 63, 63, 0), pick_gap(1'b0));
    send_command(make_item(OP_READ, 0, 0, 0), pick_gap(1'b0));
    send_command(make_item(OP_RELAX, 0, 0, 0), pick_gap(1'b0));
    send_command(make_item(OP_UNUSED, 0, 0, 0), pick_gap(1'b0));
    drain_results();

    // Random phases; each ends with a relax so every cell is below four
    for (int p = 0; p < NUM_PHASES; p++) begin
      rows = (rows_plan[p] < 0) ? $urandom_range(1, 8) : rows_plan[p];
      cols = (cols_plan[p] < 0) ? $urandom_range(1, 8) : cols_plan[p];
      resize_grid(7'(rows), 7'(cols));
      nr = (rows > GRID_HEIGHT) ? GRID_HEIGHT : rows;
      nc = (cols > GRID_WIDTH) ? GRID_WIDTH : cols;
      if (nr * nc <= 4) span = SPAN_TINY;
      else if (nr * nc <= 64) span = SPAN_MID;
      else span = SPAN_LARGE;
      burst = ($urandom_range(3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_command(random_command(nr, nc, span), pick_gap(burst));
      send_command(make_item(OP_RELAX, $urandom_range(63), $urandom_range(63),
                             $urandom_range(65535)), pick_gap(burst));
      drain_results();
    end

    if (tracker.errors == 0 && tracker.pending_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sandpile_grid_relaxer.f]
+incdir+rtl
rtl/sgr_pkg.sv
rtl/sandpile_grid_relaxer.sv
rtl/sgr_checker.sv
tb/sv/sandpile_check_pkg.sv
tb/sv/sandpile_grid_relaxer_test.sv
